[rtl/imudr_pkg.sv]
// Shared types and constants for the IMU dead-reckoning integrator.
// No dependencies; used by every module of the block.
package imudr_pkg;

   localparam int ACCEL_W = 32;
   localparam int ANGLE_W = 16;
   localparam int POS_W   = 48;
   localparam int VEL_W   = 32;
   localparam int REQ_W   = 3 * ACCEL_W + 3 * ANGLE_W;
   localparam int RSP_W   = 3 * POS_W;
   localparam int CSR_W   = 20;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   typedef enum logic [1:0] {
      CSR_SAMPLE_PERIOD  = 2'd0,
      CSR_GRAVITY        = 2'd1,
      CSR_ANGLE_DEADBAND = 2'd2,
      CSR_ACCEL_DEADBAND = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] yaw;
      logic signed [ANGLE_W-1:0] pitch;
      logic signed [ANGLE_W-1:0] roll;
      logic signed [ACCEL_W-1:0] accel_z;
      logic signed [ACCEL_W-1:0] accel_y;
      logic signed [ACCEL_W-1:0] accel_x;
   } req_item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_stat_type;

   function automatic logic signed [33:0] atan_phase(input logic [3:0] i);
      logic signed [33:0] v;
      case (i)
         4'd0:    v = 34'sh020000000;
         4'd1:    v = 34'sh012E4051D;
         4'd2:    v = 34'sh009FB385B;
         4'd3:    v = 34'sh0051111D4;
         4'd4:    v = 34'sh0028B0D43;
         4'd5:    v = 34'sh00145D7E1;
         4'd6:    v = 34'sh000A2F61E;
         4'd7:    v = 34'sh000517C55;
         4'd8:    v = 34'sh00028BE53;
         4'd9:    v = 34'sh000145F2E;
         4'd10:   v = 34'sh0000A2F98;
         4'd11:   v = 34'sh0000517CC;
         4'd12:   v = 34'sh000028BE6;
         4'd13:   v = 34'sh0000145F3;
         4'd14:   v = 34'sh00000A2F9;
         4'd15:   v = 34'sh00000517C;
         default: v = 34'sh000000000;
      endcase
      return v;
   endfunction

endpackage

[rtl/imu_dead_reckoning_integrator_top.sv]
// Channel  Dir  Width  Contents
// req      in   144    accel_x, accel_y, accel_z, roll, pitch, yaw
// rsp      out  144    pos_x, pos_y, pos_z
// csr      in   2+20   sample_period, gravity, angle_deadband, accel_deadband
//
// Each transaction is taken from the queue, then passes through three serial
// CORDIC runs (load and 16 steps) and the sequence on the shared multiplier
// (rotation, deadband, integration). A two-entry queue lets the input run
// ahead by two items.
// Reset is synchronous; a stalled response holds and blocks only the final
// load step. Depends on imudr_pkg, imudr_front, imudr_queue and imudr_back.
module imu_dead_reckoning_integrator_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,   // accel_x, accel_y, accel_z, roll, pitch, yaw
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,   // pos_x, pos_y, pos_z
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [19:0]  csr_wdata
);

   logic [15:0] sample_period_ff;
   logic [19:0] gravity_ff;
   logic [14:0] angle_deadband_ff;
   logic [15:0] accel_deadband_ff;

   imudr_pkg::queue_stat_type stat;
   imudr_pkg::req_item_type   push_data;
   imudr_pkg::req_item_type   pop_data;
   logic                      push;
   logic                      pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_period_ff  <= 16'd655;
         gravity_ff        <= 20'd642646;
         angle_deadband_ff <= 15'd2;
         accel_deadband_ff <= 16'd262;
      end else if (csr_we) begin
         case (imudr_pkg::csr_index_type'(csr_index))
            imudr_pkg::CSR_SAMPLE_PERIOD:  sample_period_ff  <= csr_wdata[15:0];
            imudr_pkg::CSR_GRAVITY:        gravity_ff        <= csr_wdata;
            imudr_pkg::CSR_ANGLE_DEADBAND: angle_deadband_ff <= csr_wdata[14:0];
            imudr_pkg::CSR_ACCEL_DEADBAND: accel_deadband_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   imudr_front u_front (
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .angle_deadband (angle_deadband_ff),
      .stat           (stat),
      .push           (push),
      .push_data      (push_data)
   );

   imudr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (stat)
   );

   imudr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .stat           (stat),
      .pop_data       (pop_data),
      .pop            (pop),
      .sample_period  (sample_period_ff),
      .gravity        (gravity_ff),
      .accel_deadband (accel_deadband_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

endmodule

[rtl/imudr_queue.sv]
// Two-entry queue between the front and back parts.
// Depends on imudr_pkg for the item and status types.
module imudr_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  imudr_pkg::req_item_type push_data,
   input  logic                    pop,
   output imudr_pkg::req_item_type pop_data,
   output imudr_pkg::queue_stat_type stat
);

   imudr_pkg::req_item_type mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign stat.empty = (count_ff == 2'd0);
   assign stat.full  = (count_ff == 2'd2);
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

[rtl/imudr_front.sv]
// Input side: takes request transactions and applies the angle deadband.
// Depends on imudr_pkg; feeds imudr_queue.
module imudr_front (
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [imudr_pkg::REQ_W-1:0]  req_tdata,
   input  logic [14:0]                  angle_deadband,
   input  imudr_pkg::queue_stat_type    stat,
   output logic                         push,
   output imudr_pkg::req_item_type      push_data
);

   imudr_pkg::req_item_type raw;

   function automatic logic signed [15:0] dband(input logic signed [15:0] a,
                                                input logic [14:0] db);
      logic [16:0] mag;
      mag = a[15] ? (17'd0 - {a[15], a}) : {1'b0, a};
      return (mag < {2'b00, db}) ? 16'sd0 : a;
   endfunction

   assign raw        = imudr_pkg::req_item_type'(req_tdata);
   assign req_tready = ~stat.full;
   assign push       = req_tvalid & ~stat.full;

   always_comb begin
      push_data       = raw;
      push_data.roll  = dband(raw.roll, angle_deadband);
      push_data.pitch = dband(raw.pitch, angle_deadband);
      push_data.yaw   = dband(raw.yaw, angle_deadband);
   end

endmodule

[rtl/imudr_back.sv]
// Execution side: CORDIC sine/cosine, rotation, deadband and integration
// on one shared multiplier; holds the response register. Uses imudr_pkg.
module imudr_back (
   input  logic                         clock,
   input  logic                         reset,
   input  imudr_pkg::queue_stat_type    stat,
   input  imudr_pkg::req_item_type      pop_data,
   output logic                         pop,
   input  logic [15:0]                  sample_period,
   input  logic [19:0]                  gravity,
   input  logic [15:0]                  accel_deadband,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [imudr_pkg::RSP_W-1:0]  rsp_tdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_CALC
   } state_type;

   localparam logic [5:0] LAST_STEP = 6'd35;

   state_type               state_ff;
   imudr_pkg::req_item_type item_ff;
   logic [1:0]              aidx_ff;
   logic [4:0]              iter_ff;
   logic signed [33:0]      x_ff, y_ff, z_ff;
   logic                    flip_ff;
   logic signed [18:0]      cos_ff [3];
   logic signed [18:0]      sin_ff [3];
   logic [5:0]              step_ff;
   logic signed [18:0]      srsp_ff, crsp_ff, t_ff;
   logic signed [18:0]      m_ff [9];
   logic signed [60:0]      acc_ff;
   logic signed [37:0]      w_ff [3];
   logic [31:0]             dd_ff;
   logic [34:0]             sq_ff;
   logic signed [31:0]      vel_ff [3];
   logic signed [47:0]      pos_ff [3];
   logic signed [58:0]      prod_ff;
   logic                    rsp_valid_ff;
   logic [imudr_pkg::RSP_W-1:0] rsp_data_ff;

   logic signed [38:0] mul_a;
   logic signed [19:0] mul_b;
   logic signed [44:0] r;
   logic signed [15:0] ang;
   logic [31:0]        ph;
   logic               ph_flip;
   logic [3:0]         ci;
   logic signed [33:0] xs, ys, xn, yn, zn, xr, yr;
   logic               quiet;
   logic signed [16:0] per;
   logic signed [16:0] dsig;
   logic               out_free;

   function automatic logic signed [44:0] rnd16(input logic signed [60:0] p);
      logic signed [60:0] s;
      s = (p + 61'sd32768) >>> 16;
      return s[44:0];
   endfunction

   function automatic logic signed [31:0] sat_vel(input logic signed [31:0] v,
                                                  input logic signed [44:0] d);
      logic signed [45:0] s;
      s = 46'(v) + 46'(d);
      if (s > 46'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (s < -46'sd2147483648) begin
         return 32'sh80000000;
      end
      return s[31:0];
   endfunction

   function automatic logic signed [47:0] sat_pos(input logic signed [47:0] v,
                                                  input logic signed [44:0] d);
      logic signed [48:0] s;
      s = 49'(v) + 49'(d);
      if (s > 49'sd140737488355327) begin
         return 48'sh7FFFFFFFFFFF;
      end else if (s < -49'sd140737488355328) begin
         return 48'sh800000000000;
      end
      return s[47:0];
   endfunction

   assign per      = signed'({1'b0, sample_period});
   assign dsig     = signed'({1'b0, accel_deadband});
   assign r        = rnd16(61'(prod_ff));
   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign pop      = (state_ff == ST_IDLE) & ~stat.empty;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      case (aidx_ff)
         2'd0:    ang = item_ff.roll;
         2'd1:    ang = item_ff.pitch;
         default: ang = item_ff.yaw;
      endcase
      ph      = {ang, 16'h0000};
      ph_flip = ph[31] ^ ph[30];
      ci      = 4'(iter_ff - 5'd1);
      xs      = x_ff >>> ci;
      ys      = y_ff >>> ci;
      if (!z_ff[33]) begin
         xn = x_ff - ys;
         yn = y_ff + xs;
         zn = z_ff - imudr_pkg::atan_phase(ci);
      end else begin
         xn = x_ff + ys;
         yn = y_ff - xs;
         zn = z_ff + imudr_pkg::atan_phase(ci);
      end
      xr = (xn + 34'sd8192) >>> 14;
      yr = (yn + 34'sd8192) >>> 14;
   end

   always_comb begin
      quiet = 1'b1;
      for (int k = 0; k < 3; k++) begin
         if (!(w_ff[k] < 38'(dsig) && w_ff[k] > -38'(dsig))) begin
            quiet = 1'b0;
         end
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         6'd0:  begin mul_a = 39'(sin_ff[0]); mul_b = 20'(sin_ff[1]); end
         6'd1:  begin mul_a = 39'(cos_ff[0]); mul_b = 20'(sin_ff[1]); end
         6'd2:  begin mul_a = 39'(cos_ff[1]); mul_b = 20'(cos_ff[2]); end
         6'd3:  begin mul_a = 39'(cos_ff[0]); mul_b = 20'(sin_ff[2]); end
         6'd4:  begin mul_a = 39'(srsp_ff);   mul_b = 20'(cos_ff[2]); end
         6'd5:  begin mul_a = 39'(sin_ff[0]); mul_b = 20'(sin_ff[2]); end
         6'd6:  begin mul_a = 39'(crsp_ff);   mul_b = 20'(cos_ff[2]); end
         6'd7:  begin mul_a = 39'(cos_ff[1]); mul_b = 20'(sin_ff[2]); end
         6'd8:  begin mul_a = 39'(cos_ff[0]); mul_b = 20'(cos_ff[2]); end
         6'd9:  begin mul_a = 39'(srsp_ff);   mul_b = 20'(sin_ff[2]); end
         6'd10: begin mul_a = 39'(sin_ff[0]); mul_b = 20'(cos_ff[2]); end
         6'd11: begin mul_a = 39'(crsp_ff);   mul_b = 20'(sin_ff[2]); end
         6'd12: begin mul_a = 39'(sin_ff[0]); mul_b = 20'(cos_ff[1]); end
         6'd13: begin mul_a = 39'(cos_ff[0]); mul_b = 20'(cos_ff[1]); end
         6'd14: begin mul_a = 39'(item_ff.accel_x); mul_b = 20'(m_ff[0]); end
         6'd15: begin mul_a = 39'(item_ff.accel_y); mul_b = 20'(m_ff[1]); end
         6'd16: begin mul_a = 39'(item_ff.accel_z); mul_b = 20'(m_ff[2]); end
         6'd17: begin mul_a = 39'(item_ff.accel_x); mul_b = 20'(m_ff[3]); end
         6'd18: begin mul_a = 39'(item_ff.accel_y); mul_b = 20'(m_ff[4]); end
         6'd19: begin mul_a = 39'(item_ff.accel_z); mul_b = 20'(m_ff[5]); end
         6'd20: begin mul_a = 39'(item_ff.accel_x); mul_b = 20'(m_ff[6]); end
         6'd21: begin mul_a = 39'(item_ff.accel_y); mul_b = 20'(m_ff[7]); end
         6'd22: begin mul_a = 39'(item_ff.accel_z); mul_b = 20'(m_ff[8]); end
         6'd23: begin mul_a = 39'(dsig); mul_b = 20'(dsig); end
         6'd24: begin
            mul_a = 39'(signed'(w_ff[0][16:0]));
            mul_b = 20'(signed'(w_ff[0][16:0]));
         end
         6'd25: begin
            mul_a = 39'(signed'(w_ff[1][16:0]));
            mul_b = 20'(signed'(w_ff[1][16:0]));
         end
         6'd26: begin
            mul_a = 39'(signed'(w_ff[2][16:0]));
            mul_b = 20'(signed'(w_ff[2][16:0]));
         end
         6'd28: begin mul_a = 39'(w_ff[0]); mul_b = 20'(per); end
         6'd29: begin mul_a = 39'(w_ff[1]); mul_b = 20'(per); end
         6'd30: begin mul_a = 39'(vel_ff[0]); mul_b = 20'(per); end
         6'd31: begin mul_a = 39'(w_ff[2]); mul_b = 20'(per); end
         6'd32: begin mul_a = 39'(vel_ff[1]); mul_b = 20'(per); end
         6'd33: begin mul_a = 39'(vel_ff[2]); mul_b = 20'(per); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 59'(mul_a) * 59'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         aidx_ff      <= 2'd0;
         iter_ff      <= 5'd0;
         step_ff      <= 6'd0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            vel_ff[k] <= '0;
            pos_ff[k] <= '0;
         end
      end else begin
         if (state_ff == ST_CALC && step_ff == LAST_STEP && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!stat.empty) begin
                  item_ff  <= pop_data;
                  aidx_ff  <= 2'd0;
                  iter_ff  <= 5'd0;
                  state_ff <= ST_CORDIC;
               end
            end
            ST_CORDIC: begin
               if (iter_ff == 5'd0) begin
                  flip_ff <= ph_flip;
                  x_ff    <= imudr_pkg::CORDIC_GAIN;
                  y_ff    <= '0;
                  z_ff    <= 34'(signed'(ph_flip ? (ph ^ 32'h80000000) : ph));
                  iter_ff <= 5'd1;
               end else begin
                  x_ff <= xn;
                  y_ff <= yn;
                  z_ff <= zn;
                  if (iter_ff == 5'd16) begin
                     cos_ff[aidx_ff] <= flip_ff ? -xr[18:0] : xr[18:0];
                     sin_ff[aidx_ff] <= flip_ff ? -yr[18:0] : yr[18:0];
                     iter_ff         <= 5'd0;
                     if (aidx_ff == 2'd2) begin
                        step_ff  <= 6'd0;
                        state_ff <= ST_CALC;
                     end else begin
                        aidx_ff <= aidx_ff + 2'd1;
                     end
                  end else begin
                     iter_ff <= iter_ff + 5'd1;
                  end
               end
            end
            ST_CALC: begin
               if (step_ff != LAST_STEP) begin
                  step_ff <= step_ff + 6'd1;
               end
               case (step_ff)
                  6'd1:  srsp_ff <= r[18:0];
                  6'd2:  crsp_ff <= r[18:0];
                  6'd3:  m_ff[0] <= r[18:0];
                  6'd4:  t_ff    <= r[18:0];
                  6'd5:  m_ff[1] <= r[18:0] - t_ff;
                  6'd6:  t_ff    <= r[18:0];
                  6'd7:  m_ff[2] <= r[18:0] + t_ff;
                  6'd8:  m_ff[3] <= r[18:0];
                  6'd9:  t_ff    <= r[18:0];
                  6'd10: m_ff[4] <= r[18:0] + t_ff;
                  6'd11: t_ff    <= r[18:0];
                  6'd12: m_ff[5] <= r[18:0] - t_ff;
                  6'd13: begin
                     m_ff[7] <= r[18:0];
                     m_ff[6] <= -sin_ff[1];
                  end
                  6'd14: m_ff[8] <= r[18:0];
                  6'd15: acc_ff <= 61'(prod_ff);
                  6'd16: acc_ff <= acc_ff + 61'(prod_ff);
                  6'd17: w_ff[0] <= 38'(rnd16(acc_ff + 61'(prod_ff)));
                  6'd18: acc_ff <= 61'(prod_ff);
                  6'd19: acc_ff <= acc_ff + 61'(prod_ff);
                  6'd20: w_ff[1] <= 38'(rnd16(acc_ff + 61'(prod_ff)));
                  6'd21: acc_ff <= 61'(prod_ff);
                  6'd22: acc_ff <= acc_ff + 61'(prod_ff);
                  6'd23: w_ff[2] <= 38'(rnd16(acc_ff + 61'(prod_ff)))
                                  - 38'(signed'({1'b0, gravity}));
                  6'd24: dd_ff <= prod_ff[31:0];
                  6'd25: sq_ff <= {3'b000, prod_ff[31:0]};
                  6'd26: sq_ff <= sq_ff + {3'b000, prod_ff[31:0]};
                  6'd27: begin
                     if (quiet && (sq_ff + {3'b000, prod_ff[31:0]} < {3'b000, dd_ff})) begin
                        for (int k = 0; k < 3; k++) begin
                           w_ff[k] <= '0;
                        end
                     end
                  end
                  6'd29: vel_ff[0] <= sat_vel(vel_ff[0], r);
                  6'd30: vel_ff[1] <= sat_vel(vel_ff[1], r);
                  6'd31: pos_ff[0] <= sat_pos(pos_ff[0], r);
                  6'd32: vel_ff[2] <= sat_vel(vel_ff[2], r);
                  6'd33: pos_ff[1] <= sat_pos(pos_ff[1], r);
                  6'd34: pos_ff[2] <= sat_pos(pos_ff[2], r);
                  6'd35: begin
                     if (out_free) begin
                        rsp_data_ff  <= {pos_ff[2], pos_ff[1], pos_ff[0]};
                        state_ff     <= ST_IDLE;
                     end
                  end
                  default: ;
               endcase
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[rtl/imudr_checker.sv]
// Port-level checks for the IMU dead-reckoning integrator.
// Bound to imu_dead_reckoning_integrator_top; no other dependencies.
module imudr_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [143:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response data changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response pending right after reset");

   a_reset_ready: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_tready)
      else $error("input not ready right after reset");

endmodule

bind imu_dead_reckoning_integrator_top imudr_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[verif/tb_imu_dead_reckoning_integrator_top.sv]
// Self-checking testbench for imu_dead_reckoning_integrator_top: drives IMU samples
// with random gaps, predicts positions with a bit-exact fixed-point integrator model.
// Depends on imudr_pkg and the integrator RTL.
module tb_imu_dead_reckoning_integrator_top;
   import imudr_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam longint VEL_HI = 64'sd2147483647;
   localparam longint VEL_LO = -64'sd2147483648;
   localparam longint POS_HI = 64'sd140737488355327;
   localparam longint POS_LO = -64'sd140737488355328;

   typedef struct packed {
      logic [47:0] pos_z;
      logic [47:0] pos_y;
      logic [47:0] pos_x;
   } pos_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [143:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CSR_SAMPLE_PERIOD;
   logic [19:0] csr_wdata = '0;

   imu_dead_reckoning_integrator_top dut (.*);

   always #4 clock = ~clock;

   req_item_type sample_queue[$];
   pos_item_type position_queue[$];
   longint period_q, gravity_q, angle_db_q, accel_db_q;
   longint vel_est[3], pos_est[3];
   int mismatches = 0, sent = 0, received = 0, idle_cycles = 0, req_gap = 0, rsp_gap = 0;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round16(longint p);
      return (p + 32768) >>> 16;
   endfunction

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic sin_cos(input longint ang, output longint c, output longint s);
      logic [31:0] ph;
      bit flip;
      longint x, y, z, xs, ys;
      ph = {ang[15:0], 16'h0};
      flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
      if (flip) ph[31] = ~ph[31];
      z = longint'(signed'(ph));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(atan_phase(4'(i)));
         end else begin
            x += ys; y -= xs; z += longint'(atan_phase(4'(i)));
         end
      end
      x = (x + 8192) >>> 14;
      y = (y + 8192) >>> 14;
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic longint apply_angle_deadband(longint a);
      longint m;
      m = a < 0 ? -a : a;
      return m < angle_db_q ? 0 : a;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic integrate_sample(input req_item_type it);
      longint acc[3], w[3], m[3][3];
      longint cr, sr, cp, sp, cy, sy, srsp, crsp, dv, ds;
      bit quiet;
      pos_item_type p;
      acc[0] = longint'(it.accel_x);
      acc[1] = longint'(it.accel_y);
      acc[2] = longint'(it.accel_z);
      sin_cos(apply_angle_deadband(longint'(it.roll)), cr, sr);
      sin_cos(apply_angle_deadband(longint'(it.pitch)), cp, sp);
      sin_cos(apply_angle_deadband(longint'(it.yaw)), cy, sy);
      srsp = round16(sr * sp);
      crsp = round16(cr * sp);
      m[0][0] = round16(cp * cy);
      m[0][1] = round16(srsp * cy) - round16(cr * sy);
      m[0][2] = round16(crsp * cy) + round16(sr * sy);
      m[1][0] = round16(cp * sy);
      m[1][1] = round16(srsp * sy) + round16(cr * cy);
      m[1][2] = round16(crsp * sy) - round16(sr * cy);
      m[2][0] = -sp;
      m[2][1] = round16(sr * cp);
      m[2][2] = round16(cr * cp);
      for (int k = 0; k < 3; k++)
         w[k] = round16(m[k][0] * acc[0] + m[k][1] * acc[1] + m[k][2] * acc[2]);
      w[2] -= gravity_q;
      quiet = 1;
      for (int k = 0; k < 3; k++)
         if ((w[k] < 0 ? -w[k] : w[k]) >= accel_db_q) quiet = 0;
      if (quiet && (w[0] * w[0] + w[1] * w[1] + w[2] * w[2] < accel_db_q * accel_db_q))
         for (int k = 0; k < 3; k++) w[k] = 0;
      for (int k = 0; k < 3; k++) begin
         dv = round16(w[k] * period_q);
         vel_est[k] = clip(vel_est[k] + dv, VEL_LO, VEL_HI);
         ds = round16(vel_est[k] * period_q);
         pos_est[k] = clip(pos_est[k] + ds, POS_LO, POS_HI);
      end
      p.pos_x = pos_est[0][47:0];
      p.pos_y = pos_est[1][47:0];
      p.pos_z = pos_est[2][47:0];
      position_queue.push_back(p);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_tready) begin
      end else if (req_tvalid && req_tready && sample_queue.size() > 0 && gap_length() != 0) begin
         req_tvalid <= 1'b0;
         req_gap = gap_length() - 1;
      end else if (req_gap > 0) begin
         req_tvalid <= 1'b0;
         req_gap--;
      end else if (sample_queue.size() > 0) begin
         req_tdata <= sample_queue[0];
         integrate_sample(sample_queue.pop_front());
         req_tvalid <= 1'b1;
      end else begin
         req_tvalid <= 1'b0;
      end
      if (!reset && req_tvalid && req_tready) sent++;
   end

   always @(posedge clock) begin
      pos_item_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            received++;
            got = rsp_tdata;
            if (position_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected position output %h", rsp_tdata);
            end else begin
               want = position_queue.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("position mismatch: expected x=%h y=%h z=%h got x=%h y=%h z=%h",
                              want.pos_x, want.pos_y, want.pos_z,
                              got.pos_x, got.pos_y, got.pos_z);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_tready <= 1'b0;
            rsp_gap--;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            rsp_gap = gap_length();
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (sample_queue.size() == 0 && position_queue.size() == 0 && !req_tvalid))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired: %0d sent, %0d received", sent, received);
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic write_register(input csr_index_type idx, input longint value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[19:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SAMPLE_PERIOD:  period_q = value & 16'hFFFF;
         CSR_GRAVITY:        gravity_q = value & 20'hFFFFF;
         CSR_ANGLE_DEADBAND: angle_db_q = value & 15'h7FFF;
         CSR_ACCEL_DEADBAND: accel_db_q = value & 16'hFFFF;
         default: ;
      endcase
   endtask

   task automatic drain();
      while (sample_queue.size() > 0 || req_tvalid || position_queue.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic req_item_type make_sample(longint ax, longint ay, longint az,
                                               longint r, longint p, longint y);
      req_item_type it;
      it.accel_x = ax[31:0]; it.accel_y = ay[31:0]; it.accel_z = az[31:0];
      it.roll = r[15:0]; it.pitch = p[15:0]; it.yaw = y[15:0];
      return it;
   endfunction

   function automatic longint rand_angle();
      case ($urandom_range(0, 3))
         0: return $signed(16'($urandom));
         1: return $signed(16'($urandom_range(0, 6))) - 3;
         2: return $urandom_range(0, 1) ? 32767 : -32768;
         default: return $signed(16'($urandom_range(0, 2047))) - 1024;
      endcase
   endfunction

   function automatic longint rand_accel();
      case ($urandom_range(0, 4))
         0: return longint'($signed($urandom));
         1: return longint'($signed($urandom_range(0, 1310720))) - 655360;
         2: return longint'($signed($urandom_range(0, 600))) - 300;
         default: return longint'($signed($urandom_range(0, 26214400))) - 13107200;
      endcase
   endfunction

   task automatic random_phase(input int n);
      for (int i = 0; i < n; i++)
         sample_queue.push_back(make_sample(rand_accel(), rand_accel(), rand_accel(),
                                            rand_angle(), rand_angle(), rand_angle()));
      drain();
   endtask

   initial begin
      period_q = 655; gravity_q = 642646; angle_db_q = 2; accel_db_q = 262;
      for (int k = 0; k < 3; k++) begin
         vel_est[k] = 0; pos_est[k] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      sample_queue.push_back(make_sample(0, 0, 642646, 0, 0, 0));
      sample_queue.push_back(make_sample(100, -100, 642700, 1, -1, 0));
      sample_queue.push_back(make_sample(2147483647, 2147483647, 2147483647, 32767, 32767, 32767));
      sample_queue.push_back(make_sample(-2147483648, -2147483648, -2147483648,
                                         -32768, -32768, -32768));
      sample_queue.push_back(make_sample(65536, 0, 0, 16384, -16384, 8192));
      sample_queue.push_back(make_sample(0, 65536, 0, -8192, 2, -2));
      sample_queue.push_back(make_sample(-1, -1, -1, -1, -1, -1));
      sample_queue.push_back(make_sample(300, 0, 642646, 0, 0, 0));
      for (int i = 0; i < 8; i++)
         sample_queue.push_back(make_sample(2147483647, -2147483648, 2147483647, 0, 0, 0));
      drain();
      write_register(CSR_SAMPLE_PERIOD, 65535);
      write_register(CSR_GRAVITY, 0);
      write_register(CSR_ANGLE_DEADBAND, 32767);
      write_register(CSR_ACCEL_DEADBAND, 65535);
      sample_queue.push_back(make_sample(1000, -1000, 500, 32766, -32767, -32768));
      sample_queue.push_back(make_sample(2147483647, 0, 0, 0, 0, 0));
      for (int i = 0; i < 6; i++)
         sample_queue.push_back(make_sample(2147483647, 2147483647, -2147483648, 0, 0, 0));
      drain();
      write_register(CSR_SAMPLE_PERIOD, 0);
      write_register(CSR_GRAVITY, 1048575);
      write_register(CSR_ANGLE_DEADBAND, 0);
      write_register(CSR_ACCEL_DEADBAND, 0);
      random_phase(60);
      write_register(CSR_SAMPLE_PERIOD, 655);
      write_register(CSR_GRAVITY, 642646);
      write_register(CSR_ANGLE_DEADBAND, 2);
      write_register(CSR_ACCEL_DEADBAND, 262);
      random_phase(200);
      write_register(CSR_SAMPLE_PERIOD, 1);
      write_register(CSR_ACCEL_DEADBAND, 40000);
      write_register(CSR_ANGLE_DEADBAND, 500);
      random_phase(100);
      write_register(CSR_SAMPLE_PERIOD, $urandom_range(1, 65535));
      write_register(CSR_GRAVITY, $urandom_range(0, 1048575));
      write_register(CSR_ANGLE_DEADBAND, $urandom_range(0, 32767));
      write_register(CSR_ACCEL_DEADBAND, $urandom_range(0, 65535));
      random_phase(140);
      $display("covered %0d samples, %0d positions checked, over five register settings",
               sent, received);
      $display("extremes of acceleration, angles, deadbands, zero period and saturation exercised");
      if (mismatches == 0 && position_queue.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
